>>> design/dtrs_pkg.sv
// Package for the delay tap ramp sequencer.
// Holds the field widths, the tap step and the controller/datapath command and status types.
package dtrs_pkg;

    localparam int LANE_W = 4;
    localparam int TAP_W  = 9;
    localparam int MASK_W = 9;

    localparam logic [TAP_W-1:0]  TAP_STEP  = 9'd8;
    localparam logic [LANE_W-1:0] MASK_LANES = 4'd9;

    typedef struct packed {
        logic load;
        logic fetch;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic equal;
        logic final_step;
    } t_status;

endpackage

>>> design/dtrs_req_if.sv
// Request channel interface: lane and target delay with valid/ready.
// Depends on dtrs_pkg for field widths.
interface dtrs_req_if;
    logic                       valid;
    logic                       ready;
    logic [dtrs_pkg::LANE_W-1:0] lane;
    logic [dtrs_pkg::TAP_W-1:0]  target_delay;

    modport source (output valid, output lane, output target_delay, input ready);
    modport sink (input valid, input lane, input target_delay, output ready);
endinterface

>>> design/dtrs_wr_if.sv
// Delay-write channel interface: select mask, tap value and last flag with valid/ready.
// Depends on dtrs_pkg for field widths.
interface dtrs_wr_if;
    logic                        valid;
    logic                        ready;
    logic [dtrs_pkg::MASK_W-1:0] select_mask;
    logic [dtrs_pkg::TAP_W-1:0]  tap_value;
    logic                        last;

    modport source (output valid, output select_mask, output tap_value, output last,
                    input ready);
    modport sink (input valid, input select_mask, input tap_value, input last,
                  output ready);
endinterface

>>> design/dtrs_ctrl.sv
// Controller state machine for the delay tap ramp sequencer.
// Drives datapath commands and the channel handshakes; depends on dtrs_pkg.
module dtrs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic              i_wr_ready,
    output logic              o_wr_valid,
    input  dtrs_pkg::t_status i_status,
    output dtrs_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_wr_valid, n_wr_valid;
    logic       slot_free;

    assign slot_free   = !r_wr_valid || i_wr_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_wr_valid  = r_wr_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd.load  = 1'b0;
        o_cmd.fetch = 1'b0;
        o_cmd.step  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.fetch = 1'b1;
                if (!i_status.in_range || i_status.equal) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (slot_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.final_step) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.step) begin
            n_wr_valid = 1'b1;
        end else if (i_wr_ready) begin
            n_wr_valid = 1'b0;
        end else begin
            n_wr_valid = r_wr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wr_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_valid <= n_wr_valid;
        end
    end

endmodule

>>> design/dtrs_datapath.sv
// Datapath of the delay tap ramp sequencer: per-lane tap registers, ramp walker, write register.
// Depends on dtrs_pkg; commanded by dtrs_ctrl.
module dtrs_datapath #(
    parameter int DQ_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dtrs_pkg::t_cmd                i_cmd,
    output dtrs_pkg::t_status             o_status,
    input  logic [dtrs_pkg::LANE_W-1:0]   i_lane,
    input  logic [dtrs_pkg::TAP_W-1:0]    i_target_delay,
    output logic [dtrs_pkg::MASK_W-1:0]   o_select_mask,
    output logic [dtrs_pkg::TAP_W-1:0]    o_tap_value,
    output logic                          o_last
);

    localparam int NUM_LANES = DQ_BITS + 1;
    localparam int IDX_W     = $clog2(NUM_LANES);

    logic [dtrs_pkg::TAP_W-1:0]  r_taps [NUM_LANES];
    logic [dtrs_pkg::LANE_W-1:0] r_lane;
    logic [dtrs_pkg::TAP_W-1:0]  r_target;
    logic [dtrs_pkg::TAP_W-1:0]  r_cur;
    logic [dtrs_pkg::MASK_W-1:0] r_mask;
    logic [dtrs_pkg::MASK_W-1:0] r_out_mask;
    logic [dtrs_pkg::TAP_W-1:0]  r_out_tap;
    logic                        r_out_last;

    logic [IDX_W-1:0]            lane_idx;
    logic                        in_range;
    logic [dtrs_pkg::TAP_W-1:0]  tap_rd;
    logic [dtrs_pkg::MASK_W-1:0] n_mask;
    logic                        up;
    logic [dtrs_pkg::TAP_W-1:0]  diff;
    logic                        final_step;
    logic [dtrs_pkg::TAP_W-1:0]  n_cur;

    assign lane_idx = IDX_W'({1'b0, r_lane});
    assign in_range = ({28'd0, r_lane} <= 32'(DQ_BITS));
    assign tap_rd   = in_range ? r_taps[lane_idx] : '0;
    assign n_mask   = (r_lane < dtrs_pkg::MASK_LANES)
                      ? (dtrs_pkg::MASK_W'(1) << r_lane) : '0;

    assign up         = (r_target > r_cur);
    assign diff       = up ? (r_target - r_cur) : (r_cur - r_target);
    assign final_step = (diff <= dtrs_pkg::TAP_STEP);
    assign n_cur      = up ? (r_cur + dtrs_pkg::TAP_STEP) : (r_cur - dtrs_pkg::TAP_STEP);

    assign o_status.in_range   = in_range;
    assign o_status.equal      = (tap_rd == r_target);
    assign o_status.final_step = final_step;

    assign o_select_mask = r_out_mask;
    assign o_tap_value   = r_out_tap;
    assign o_last        = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                r_taps[i] <= '0;
            end
        end else if (i_cmd.step && final_step) begin
            r_taps[lane_idx] <= r_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lane   <= i_lane;
            r_target <= i_target_delay;
        end
        if (i_cmd.fetch) begin
            r_cur  <= tap_rd;
            r_mask <= n_mask;
        end else if (i_cmd.step) begin
            r_cur <= n_cur;
        end
        if (i_cmd.step) begin
            r_out_mask <= r_mask;
            r_out_tap  <= final_step ? r_target : n_cur;
            r_out_last <= final_step;
        end
    end

endmodule

>>> design/delay_tap_ramp_sequencer.sv
// Delay tap ramp sequencer top level: walks a lane's tap to the target in steps of 8.
// First write: valid after the load, the lane tap fetch and the first ramp step are registered.
// Throughput: a request moving a tap by d emits ceil(d/8) writes, one per cycle while the
// write channel is not stalled, through the single ramp adder, after the lane lookup.
// Reset: synchronous active low; clears all lane taps to zero and empties the write register.
module delay_tap_ramp_sequencer #(
    parameter int DQ_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dtrs_req_if.sink      i_req,
    dtrs_wr_if.source     o_wr
);

    dtrs_pkg::t_cmd    cmd;
    dtrs_pkg::t_status status;

    dtrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_wr_ready  (o_wr.ready),
        .o_wr_valid  (o_wr.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dtrs_datapath #(
        .DQ_BITS (DQ_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_lane         (i_req.lane),
        .i_target_delay (i_req.target_delay),
        .o_select_mask  (o_wr.select_mask),
        .o_tap_value    (o_wr.tap_value),
        .o_last         (o_wr.last)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("request accepted while a ramp was starting");

    a_ramp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.valid && !o_wr.last |-> !i_req.ready)
        else $error("request channel open in the middle of a ramp");

    a_onehot_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.valid |-> $onehot0(o_wr.select_mask))
        else $error("select mask not one-hot");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.fetch, cmd.step}))
        else $error("controller issued overlapping commands");
`endif

endmodule

>>> tb/delay_tap_ramp_sequencer_tb.sv
`timescale 1ns / 100ps
// Testbench for delay_tap_ramp_sequencer: predicts the per-lane tap ramp and checks every write.
// Depends on dtrs_pkg, dtrs_req_if and dtrs_wr_if from the design folder.
module delay_tap_ramp_sequencer_tb;

    localparam int DQ_BITS       = 8;
    localparam int NUM_LANES     = DQ_BITS + 1;
    localparam int IDLE_PCT      = 32;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS  = 228;
    localparam int CALM_ITEMS    = 60;
    localparam int STALL_CYCLES  = 300;

    typedef struct packed {
        logic [dtrs_pkg::MASK_W-1:0] select_mask;
        logic [dtrs_pkg::TAP_W-1:0]  tap_value;
        logic                        last;
    } t_tap_write;

    logic i_clk;
    logic i_rst_n;

    dtrs_req_if req_bus();
    dtrs_wr_if  wr_bus();

    delay_tap_ramp_sequencer #(
        .DQ_BITS(DQ_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_wr   (wr_bus)
    );

    logic [dtrs_pkg::TAP_W-1:0] lane_taps [NUM_LANES];
    t_tap_write                 pending_writes [$];

    int fail_count       = 0;
    int writes_checked   = 0;
    int requests_sent    = 0;
    int requests_ignored = 0;
    int cycle_count      = 0;
    int sink_hold        = 0;
    bit src_idle_on      = 1'b0;
    bit sink_idle_on     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d writes outstanding",
                     cycle_count, pending_writes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        wr_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                wr_bus.ready <= 1'b0;
                sink_hold = sink_hold - 1;
            end else if (sink_idle_on) begin
                wr_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                wr_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_tap_write want;
        if (i_rst_n && wr_bus.valid && wr_bus.ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write: select_mask %h tap_value %h last %b",
                       wr_bus.select_mask, wr_bus.tap_value, wr_bus.last);
                fail_count++;
            end else begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (wr_bus.select_mask !== want.select_mask) begin
                    $error("select_mask mismatch: expected %h, actual %h",
                           want.select_mask, wr_bus.select_mask);
                    fail_count++;
                end
                if (wr_bus.tap_value !== want.tap_value) begin
                    $error("tap_value mismatch: expected %h, actual %h",
                           want.tap_value, wr_bus.tap_value);
                    fail_count++;
                end
                if (wr_bus.last !== want.last) begin
                    $error("last mismatch: expected %b, actual %b", want.last, wr_bus.last);
                    fail_count++;
                end
            end
        end
    end

    function automatic void predict_ramp(input logic [dtrs_pkg::LANE_W-1:0] lane,
                                         input logic [dtrs_pkg::TAP_W-1:0]  tgt);
        t_tap_write w;
        int         cur;
        int         goal;
        int         step;
        if (lane > DQ_BITS) begin
            requests_ignored++;
            return;
        end
        cur  = int'(lane_taps[lane]);
        goal = int'(tgt);
        step = int'(dtrs_pkg::TAP_STEP);
        w.select_mask       = '0;
        w.select_mask[lane] = 1'b1;
        if (cur == goal)
            return;
        w.last = 1'b0;
        if (cur > goal) begin
            while (cur - goal > step) begin
                cur         = cur - step;
                w.tap_value = dtrs_pkg::TAP_W'(cur);
                pending_writes.push_back(w);
            end
        end else begin
            while (goal - cur > step) begin
                cur         = cur + step;
                w.tap_value = dtrs_pkg::TAP_W'(cur);
                pending_writes.push_back(w);
            end
        end
        w.tap_value = tgt;
        w.last      = 1'b1;
        pending_writes.push_back(w);
        lane_taps[lane] = tgt;
    endfunction

    task automatic send_request(input logic [dtrs_pkg::LANE_W-1:0] lane,
                                input logic [dtrs_pkg::TAP_W-1:0]  tgt);
        if (src_idle_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                req_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_bus.valid        <= 1'b1;
        req_bus.lane         <= lane;
        req_bus.target_delay <= tgt;
        do @(posedge i_clk); while (!req_bus.ready);
        requests_sent++;
        predict_ramp(lane, tgt);
    endtask

    task automatic drain_writes();
        req_bus.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_full_range();
        send_request(4'd0, 9'h1ff);
        send_request(4'd0, 9'h000);
        send_request(4'd8, 9'h1ff);
        send_request(4'd8, 9'h100);
        drain_writes();
    endtask

    task automatic test_step_boundaries();
        send_request(4'd1, 9'd1);
        send_request(4'd1, 9'd8);
        send_request(4'd1, 9'd16);
        send_request(4'd1, 9'd25);
        send_request(4'd1, 9'd41);
        send_request(4'd1, 9'd58);
        send_request(4'd1, 9'd50);
        send_request(4'd1, 9'd41);
        send_request(4'd1, 9'd25);
        send_request(4'd1, 9'd8);
        send_request(4'd1, 9'd1);
        send_request(4'd1, 9'd0);
        drain_writes();
    endtask

    task automatic test_equal_target();
        send_request(4'd1, 9'd0);
        send_request(4'd2, 9'd0);
        send_request(4'd8, 9'h100);
        drain_writes();
    endtask

    task automatic test_lane_out_of_range();
        for (int ln = DQ_BITS + 1; ln < (1 << dtrs_pkg::LANE_W); ln++)
            send_request(dtrs_pkg::LANE_W'(ln), (ln % 2) ? 9'h1ff : 9'h0aa);
        send_request(4'd7, 9'd3);
        drain_writes();
    endtask

    task automatic test_write_stall();
        sink_hold <= STALL_CYCLES;
        send_request(4'd2, 9'h1ff);
        send_request(4'd3, 9'h155);
        send_request(4'd4, 9'h0aa);
        send_request(4'd5, 9'h1f0);
        send_request(4'd6, 9'h10f);
        drain_writes();
    endtask

    task automatic test_random_ramps();
        int                          counted;
        int                          pick;
        int                          goal;
        logic [dtrs_pkg::LANE_W-1:0] lane;
        logic [dtrs_pkg::TAP_W-1:0]  tgt;
        counted = 0;
        src_idle_on  <= 1'b0;
        sink_idle_on <= 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (counted == CALM_ITEMS) begin
                src_idle_on  <= 1'b1;
                sink_idle_on <= 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                lane = dtrs_pkg::LANE_W'($urandom_range((1 << dtrs_pkg::LANE_W) - 1,
                                                        DQ_BITS + 1));
                tgt  = dtrs_pkg::TAP_W'($urandom_range((1 << dtrs_pkg::TAP_W) - 1));
            end else begin
                lane = dtrs_pkg::LANE_W'($urandom_range(DQ_BITS));
                if (pick < 16) begin
                    tgt = lane_taps[lane];
                end else if (pick < 66) begin
                    goal = int'(lane_taps[lane]) + int'($urandom_range(80)) - 40;
                    if (goal < 0)
                        goal = 0;
                    if (goal > (1 << dtrs_pkg::TAP_W) - 1)
                        goal = (1 << dtrs_pkg::TAP_W) - 1;
                    tgt = dtrs_pkg::TAP_W'(goal);
                end else begin
                    tgt = dtrs_pkg::TAP_W'($urandom_range((1 << dtrs_pkg::TAP_W) - 1));
                end
            end
            send_request(lane, tgt);
            counted++;
        end
        drain_writes();
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.lane         = '0;
        req_bus.target_delay = '0;
        for (int ln = 0; ln < NUM_LANES; ln++)
            lane_taps[ln] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        src_idle_on  <= 1'b1;
        sink_idle_on <= 1'b1;

        test_full_range();
        test_step_boundaries();
        test_equal_target();
        test_lane_out_of_range();
        test_write_stall();
        test_random_ramps();

        $display("Sent %0d lane requests (%0d on unused lanes), checked %0d delay writes.",
                 requests_sent, requests_ignored, writes_checked);
        $display("Covered full-range ramps, step boundaries, equal targets and a long write stall.");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
